// ===== rtl/invc_pkg.sv =====
// Shared types and constants of the inversion counter.
// No dependencies; used by every module of the block.
package invc_pkg;

    // Widths fixed by the word formats
    localparam int VALUE_W  = 32;
    localparam int INV_W    = 11;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // Default capacity of the chain
    localparam int MAX_ITEMS_DEF = 64;

    // Running total saturates here
    localparam logic [INV_W-1:0] TOTAL_MAX = {INV_W{1'b1}};

    // Control bits that travel with a value along the chain
    typedef struct packed {
        logic valid;   // slot holds a value
        logic last;    // value closes its sequence
        logic ovf;     // value arrived beyond capacity, never compared
        logic placed;  // value has been written into its cell
    } tok_ctrl_t;

endpackage

// ===== rtl/inversion_counter.sv =====
// Top level of the inversion counter: input position counter, cell chain
// and result stage. Depends on invc_pkg, invc_cell and invc_acc.
//
// Counts the pairs of a sequence of signed 32-bit words in which an earlier
// word is strictly greater than a later one; s_tlast closes the sequence and
// its result word carries the count (saturating at 2047) and a too_long flag
// for words dropped beyond MAX_ITEMS. The block takes one word per cycle.
// Each word walks a chain of MAX_ITEMS cells, one cell per cycle while the chain
// advances, counting the greater stored words it passes and writing itself into
// the cell of its own position; the result word is registered once the closing
// word leaves the last cell. Input stalls only while a result has reached the end
// of the chain and the previous result is still waiting on m_tready.
module inversion_counter import invc_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [10:0] inversions, [15:11] zero
    output logic                m_tuser    // [0] too_long
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS);

    tok_ctrl_t                 ctrl_s [MAX_ITEMS+1];
    logic signed [VALUE_W-1:0] key_s  [MAX_ITEMS+1];
    logic        [IDX_W-1:0]   dist_s [MAX_ITEMS+1];
    logic        [CNT_W-1:0]   cnt_s  [MAX_ITEMS+1];

    logic             adv;
    logic             accept;
    logic [IDX_W-1:0] pos_reg;
    logic             full_reg;

    // Chain moves unless a result word would land on a waiting one
    assign adv      = !(m_tvalid && !m_tready && ctrl_s[MAX_ITEMS].valid
                        && ctrl_s[MAX_ITEMS].last);
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // Position of the next word within its sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            full_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                pos_reg  <= '0;
                full_reg <= 1'b0;
            end else if (!full_reg) begin
                if (pos_reg == IDX_W'(MAX_ITEMS - 1)) begin
                    full_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    // Head of the chain
    always_comb begin
        ctrl_s[0].valid  = s_tvalid;
        ctrl_s[0].last   = s_tlast;
        ctrl_s[0].ovf    = full_reg;
        ctrl_s[0].placed = 1'b0;
        key_s[0]         = s_tdata[VALUE_W-1:0];
        dist_s[0]        = pos_reg;
        cnt_s[0]         = '0;
    end

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        invc_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_ctrl  (ctrl_s[i]),
            .in_key   (key_s[i]),
            .in_dist  (dist_s[i]),
            .in_cnt   (cnt_s[i]),
            .out_ctrl (ctrl_s[i+1]),
            .out_key  (key_s[i+1]),
            .out_dist (dist_s[i+1]),
            .out_cnt  (cnt_s[i+1])
        );
    end

    invc_acc #(
        .CNT_W (CNT_W)
    ) u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .tail_ctrl (ctrl_s[MAX_ITEMS]),
        .tail_cnt  (cnt_s[MAX_ITEMS]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/invc_cell.sv =====
// One cell of the comparison chain: holds one stored value and passes
// the travelling value on, counting it if the stored value is greater.
// Depends on invc_pkg.
module invc_cell import invc_pkg::*; #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  tok_ctrl_t                 in_ctrl,
    input  logic signed [VALUE_W-1:0] in_key,
    input  logic        [IDX_W-1:0]   in_dist,
    input  logic        [CNT_W-1:0]   in_cnt,
    output tok_ctrl_t                 out_ctrl,
    output logic signed [VALUE_W-1:0] out_key,
    output logic        [IDX_W-1:0]   out_dist,
    output logic        [CNT_W-1:0]   out_cnt
);

    logic signed [VALUE_W-1:0] held_reg;
    tok_ctrl_t                 ctrl_reg;
    tok_ctrl_t                 ctrl_next;
    logic signed [VALUE_W-1:0] key_reg;
    logic        [IDX_W-1:0]   dist_reg;
    logic        [IDX_W-1:0]   dist_next;
    logic        [CNT_W-1:0]   cnt_reg;
    logic        [CNT_W-1:0]   cnt_next;
    logic                      active;
    logic                      store;
    logic                      greater;

    // Value still looking for its slot; it lands here when the distance runs out
    assign active  = in_ctrl.valid && !in_ctrl.ovf && !in_ctrl.placed;
    assign store   = active && (in_dist == '0);
    assign greater = active && (in_dist != '0) && (held_reg > in_key);

    always_comb begin
        ctrl_next        = in_ctrl;
        ctrl_next.placed = in_ctrl.placed || store;
        dist_next        = (active && !store) ? in_dist - 1'b1 : in_dist;
        cnt_next         = in_cnt + CNT_W'(greater);
    end

    // Stored value: payload, written once per sequence position
    always_ff @(posedge aclk) begin
        if (adv && store) begin
            held_reg <= in_key;
        end
    end

    // Hand-over register towards the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (adv) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg  <= in_key;
            dist_reg <= dist_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_key  = key_reg;
    assign out_dist = dist_reg;
    assign out_cnt  = cnt_reg;

endmodule

// ===== rtl/invc_acc.sv =====
// Running total at the end of the chain and the result word register.
// Depends on invc_pkg.
module invc_acc import invc_pkg::*; #(
    parameter int CNT_W = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  tok_ctrl_t           tail_ctrl,
    input  logic [CNT_W-1:0]    tail_cnt,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    logic [INV_W-1:0] total_reg;
    logic [INV_W-1:0] total_next;
    logic             oflow_reg;
    logic             oflow_next;
    logic             out_valid_reg;
    logic [INV_W-1:0] out_inv_reg;
    logic             out_long_reg;
    logic [INV_W:0]   sum;
    logic             take;

    assign take = adv && tail_ctrl.valid;

    // Saturating add of this value's count
    always_comb begin
        sum        = {1'b0, total_reg} + (INV_W+1)'(tail_cnt);
        total_next = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[INV_W-1:0];
        oflow_next = oflow_reg || tail_ctrl.ovf;
    end

    // Per-sequence state, cleared by the closing word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            oflow_reg <= 1'b0;
        end else if (take) begin
            if (tail_ctrl.last) begin
                total_reg <= '0;
                oflow_reg <= 1'b0;
            end else begin
                total_reg <= total_next;
                oflow_reg <= oflow_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && tail_ctrl.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && tail_ctrl.last) begin
            out_inv_reg  <= total_next;
            out_long_reg <= oflow_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_inv_reg);
    assign m_tuser  = out_long_reg;

endmodule

// ===== rtl/invc_checker.sv =====
// Port-level checks of the inversion counter, bound to the top level.
// Depends on invc_pkg.
module invc_checker import invc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // A result word waiting on the sink holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Padding bits above the count stay clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:INV_W] == '0)
        else $error("result padding not zero");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

endmodule

bind inversion_counter invc_checker u_invc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/inversion_counter_tb.sv =====
// Self-checking testbench for inversion_counter: drives value streams and checks result words.
// Depends on invc_pkg and the inversion_counter RTL only; holds its own predictor of the count.
module inversion_counter_tb;
    import invc_pkg::*;

    localparam int CAPACITY     = MAX_ITEMS_DEF;
    localparam int RANDOM_WORDS = 1450;
    localparam int CALM_WORDS   = 250;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

    // Value patterns used for generated sequences
    typedef enum int {
        PAT_RANDOM,
        PAT_NARROW,
        PAT_EXTREME,
        PAT_FALLING,
        PAT_RISING
    } seq_pattern_e;

    typedef struct {
        logic [INV_W-1:0] inversions;
        logic             too_long;
    } inv_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    // Predictor state for the open sequence
    logic signed [31:0] held_vals [CAPACITY];
    int                 held_n;
    int                 run_total;
    logic               dropped;

    inv_result_t        inv_expected [$];
    int                 err_count   = 0;
    int                 words_sent  = 0;
    int                 cycle_count = 0;
    bit                 calm        = 1'b0;

    inversion_counter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("inversion_counter_tb failed");
            $finish;
        end
    end

    // Count the held words greater than the new one; close the sequence on last
    function automatic void count_inversions(input logic [31:0] word_val,
                                             input logic word_last);
        int          greater;
        inv_result_t res;
        greater = 0;
        if (held_n < CAPACITY) begin
            for (int i = 0; i < held_n; i++)
                if (held_vals[i] > $signed(word_val))
                    greater++;
            run_total += greater;
            if (run_total > int'(TOTAL_MAX))
                run_total = int'(TOTAL_MAX);
            held_vals[held_n] = $signed(word_val);
            held_n++;
        end else begin
            dropped = 1'b1;
        end
        if (word_last) begin
            res.inversions = run_total[INV_W-1:0];
            res.too_long   = dropped;
            inv_expected.push_back(res);
            held_n    = 0;
            run_total = 0;
            dropped   = 1'b0;
        end
    endfunction

    // Result side: random back-pressure bursts, none once calm
    always @(posedge aclk) begin
        static int stall_left = 0;
        if (calm) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin
        inv_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (inv_expected.size() == 0) begin
                $error("result word with no expectation: inversions=%0d too_long=%0b",
                       m_tdata[INV_W-1:0], m_tuser);
                err_count++;
            end else begin
                exp_res = inv_expected.pop_front();
                if (m_tdata[INV_W-1:0] !== exp_res.inversions) begin
                    $error("inversions: expected %0d, got %0d",
                           exp_res.inversions, m_tdata[INV_W-1:0]);
                    err_count++;
                end
                if (m_tuser !== exp_res.too_long) begin
                    $error("too_long: expected %0b, got %0b", exp_res.too_long, m_tuser);
                    err_count++;
                end
                if (m_tdata[M_DATA_W-1:INV_W] !== '0) begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[M_DATA_W-1:INV_W]);
                    err_count++;
                end
            end
        end
    end

    // Send one word; returns in the step it is accepted, tvalid still high
    task automatic send_word(input logic [31:0] word_val, input logic word_last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tdata  <= word_val;
        s_tlast  <= word_last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        count_inversions(word_val, word_last);
        words_sent++;
    endtask

    // Drop tvalid and wait for every outstanding result word
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (inv_expected.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // One sequence of len words in the given pattern, last on the final word
    task automatic send_sequence(input int len, input seq_pattern_e pat);
        logic [31:0] word_val;
        logic [31:0] ramp;
        ramp = (pat == PAT_FALLING) ? VAL_MAX - $urandom_range(0, 1000)
                                    : VAL_MIN + $urandom_range(0, 1000);
        for (int i = 0; i < len; i++) begin
            case (pat)
                PAT_NARROW:  word_val = 32'($urandom_range(0, 6)) - 32'd3;
                PAT_EXTREME: begin
                    case ($urandom_range(0, 4))
                        0:       word_val = VAL_MIN;
                        1:       word_val = VAL_MAX;
                        2:       word_val = '0;
                        3:       word_val = '1;
                        default: word_val = 32'd1;
                    endcase
                end
                PAT_FALLING: begin
                    ramp     = ramp - 32'($urandom_range(0, 3));
                    word_val = ramp;
                end
                PAT_RISING: begin
                    ramp     = ramp + 32'($urandom_range(0, 3));
                    word_val = ramp;
                end
                default:     word_val = $urandom;
            endcase
            send_word(word_val, i == len - 1);
        end
    endtask

    // Extremes, sign ordering, equal words and lone closing words
    task automatic test_directed();
        send_word(VAL_MIN, 1'b1);           // lone word gives zero
        send_word(VAL_MAX, 1'b1);
        send_word(VAL_MAX, 1'b0);           // falling across the sign boundary: 6
        send_word(32'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(VAL_MIN, 1'b1);
        send_word(32'd5, 1'b0);             // equal words never count
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b1);
        send_word(VAL_MIN, 1'b0);           // rising extremes: 0
        send_word(VAL_MAX, 1'b1);
        send_word(32'd1, 1'b0);             // positive before negative: 1
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h5555_5555, 1'b0);     // alternating bit patterns
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
    endtask

    // Full chain, one word past it, and flag clearing afterwards
    task automatic test_capacity();
        send_sequence(CAPACITY, PAT_FALLING);     // near-worst-case count, no overflow
        send_sequence(CAPACITY, PAT_RISING);
        send_sequence(CAPACITY + 1, PAT_FALLING); // closing word itself dropped
        send_sequence(CAPACITY + 9, PAT_RANDOM);
        send_sequence(3, PAT_RANDOM);             // overflow flag must be clear again
    endtask

    // Sender waits for the pipeline to empty between sequences
    task automatic test_drain_pause();
        send_sequence(7, PAT_RANDOM);
        hold_until_drained();
        send_sequence(1, PAT_EXTREME);
        hold_until_drained();
        send_sequence(20, PAT_NARROW);
    endtask

    // Mostly short sequences, some around and beyond capacity
    task automatic test_random_sequences();
        int           base;
        int           len;
        seq_pattern_e pat;
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 12);
                6, 7:             len = $urandom_range(13, CAPACITY - 1);
                8:                len = $urandom_range(CAPACITY - 1, CAPACITY + 1);
                default:          len = $urandom_range(CAPACITY + 2, CAPACITY + 16);
            endcase
            pat = seq_pattern_e'($urandom_range(0, 4));
            if (words_sent - base >= RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            send_sequence(len, pat);
        end
    endtask

    initial begin
        held_n    = 0;
        run_total = 0;
        dropped   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_capacity();
        test_drain_pause();
        test_random_sequences();

        // Let the chain empty, then watch for stray result words
        s_tvalid <= 1'b0;
        while (inv_expected.size() != 0) @(posedge aclk);
        repeat (CAPACITY + 20) @(posedge aclk);

        if (err_count == 0)
            $display("inversion_counter_tb passed");
        else
            $display("inversion_counter_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/invc_pkg.sv
rtl/invc_cell.sv
rtl/invc_acc.sv
rtl/inversion_counter.sv
rtl/invc_checker.sv
tb/inversion_counter_tb.sv
